@@ design/dcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// dcdf_pkg: shared types, constants and helpers
// Holds the curve geometry, the configuration register map and the record
// types that travel down the interpolation pipeline.
// ----------------------------------------------------------------------------
package dcdf_pkg;

  // Number of breakpoints on each curve.
  localparam int unsigned CURVE_POINTS = 4;

  // Breakpoints that the packed registers can hold.
  localparam int unsigned X_REG_W      = 32;
  localparam int unsigned Y_REG_W      = 64;
  localparam int unsigned X_PT_W       = 8;
  localparam int unsigned Y_PT_W       = 16;
  localparam int unsigned X_REG_POINTS = X_REG_W / X_PT_W;
  localparam int unsigned Y_REG_POINTS = Y_REG_W / Y_PT_W;

  // Interpolation arithmetic widths.
  localparam int unsigned XS_W   = X_PT_W + 1;       // common signed X domain
  localparam int unsigned SPAN_W = X_PT_W;           // x - x1 and x2 - x1
  localparam int unsigned PROD_W = Y_PT_W + SPAN_W;  // |dy| * (x - x1)

  // Divider: one quotient bit per step, a few steps per stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = Y_PT_W / DIV_BITS_PER_STAGE;

  // Segment select, multiply, divider stages, final add, output register.
  localparam int unsigned PIPE_LATENCY = 2 + DIV_STAGES + 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = Y_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_CURVE_X  = 3'd0,
    CFG_VOLT_CURVE_Y  = 3'd1,
    CFG_TEMP_CURVE_X  = 3'd2,
    CFG_TEMP_CURVE_Y  = 3'd3,
    CFG_NO_DERATING   = 3'd4,
    CFG_MAX_DERATING  = 3'd5,
    CFG_SENSOR_PRESENT = 3'd6
  } cfg_idx_e;

  localparam logic [Y_PT_W-1:0] NO_DERATING_RESET  = 16'd1000;
  localparam logic [Y_PT_W-1:0] MAX_DERATING_RESET = 16'd0;
  localparam logic [1:0]        SENSOR_PRESENT_RESET = 2'b11;

  localparam int unsigned SENSOR_VOLT_BIT = 0;
  localparam int unsigned SENSOR_TEMP_BIT = 1;

  typedef struct packed {
    logic [X_REG_W-1:0] volt_x;
    logic [Y_REG_W-1:0] volt_y;
    logic [X_REG_W-1:0] temp_x;
    logic [Y_REG_W-1:0] temp_y;
    logic [Y_PT_W-1:0]  no_der;
    logic [Y_PT_W-1:0]  max_der;
    logic [1:0]         present;
  } cfg_t;

  typedef logic [CURVE_POINTS-1:0][XS_W-1:0]   xvec_t;
  typedef logic [CURVE_POINTS-1:0][Y_PT_W-1:0] yvec_t;

  // Record entering the multiplier.
  typedef struct packed {
    logic              vld;
    logic [Y_PT_W-1:0] base;
    logic              neg;
    logic [Y_PT_W-1:0] dmag;
    logic [SPAN_W-1:0] num;
    logic [SPAN_W-1:0] den;
  } mul_rec_t;

  // Record moving through the divider. lq holds the dividend bits not yet
  // consumed in its upper part and the quotient bits found so far below.
  typedef struct packed {
    logic              vld;
    logic [Y_PT_W-1:0] base;
    logic              neg;
    logic [SPAN_W-1:0] den;
    logic [SPAN_W-1:0] rem;
    logic [Y_PT_W-1:0] lq;
  } div_rec_t;

  // Breakpoint i of a packed X register, widened into the signed X domain.
  // Points that the register cannot hold read as zero.
  function automatic logic [XS_W-1:0] x_point(input logic [X_REG_W-1:0] xr,
                                              input int unsigned i,
                                              input logic is_signed);
    logic [X_PT_W-1:0] b;
    b = '0;
    if (i < X_REG_POINTS) begin
      b = xr[X_PT_W*i +: X_PT_W];
    end
    return {is_signed & b[X_PT_W-1], b};
  endfunction

  function automatic logic [Y_PT_W-1:0] y_point(input logic [Y_REG_W-1:0] yr,
                                                input int unsigned i);
    logic [Y_PT_W-1:0] w;
    w = '0;
    if (i < Y_REG_POINTS) begin
      w = yr[Y_PT_W*i +: Y_PT_W];
    end
    return w;
  endfunction

endpackage

@@ design/dcdf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dcdf_cfg_regs: configuration register file
// Write-only registers for both curves, the fallback values and the sensor
// presence mask.
// ----------------------------------------------------------------------------
module dcdf_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dcdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcdf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output dcdf_pkg::cfg_t                  cfg_o
);

  dcdf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dcdf_pkg::cfg_idx_e'(cfg_idx_i))
        dcdf_pkg::CFG_VOLT_CURVE_X:   cfg_d.volt_x  = cfg_wdata_i[dcdf_pkg::X_REG_W-1:0];
        dcdf_pkg::CFG_VOLT_CURVE_Y:   cfg_d.volt_y  = cfg_wdata_i[dcdf_pkg::Y_REG_W-1:0];
        dcdf_pkg::CFG_TEMP_CURVE_X:   cfg_d.temp_x  = cfg_wdata_i[dcdf_pkg::X_REG_W-1:0];
        dcdf_pkg::CFG_TEMP_CURVE_Y:   cfg_d.temp_y  = cfg_wdata_i[dcdf_pkg::Y_REG_W-1:0];
        dcdf_pkg::CFG_NO_DERATING:    cfg_d.no_der  = cfg_wdata_i[dcdf_pkg::Y_PT_W-1:0];
        dcdf_pkg::CFG_MAX_DERATING:   cfg_d.max_der = cfg_wdata_i[dcdf_pkg::Y_PT_W-1:0];
        dcdf_pkg::CFG_SENSOR_PRESENT: cfg_d.present = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{volt_x:  '0,
                 volt_y:  '0,
                 temp_x:  '0,
                 temp_y:  '0,
                 no_der:  dcdf_pkg::NO_DERATING_RESET,
                 max_der: dcdf_pkg::MAX_DERATING_RESET,
                 present: dcdf_pkg::SENSOR_PRESENT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/dcdf_div_stage.sv @@
// ----------------------------------------------------------------------------
// dcdf_div_stage: one registered stage of the restoring divider
// Produces a few quotient bits of |dy|*(x-x1) / (x2-x1) per stage.
// ----------------------------------------------------------------------------
module dcdf_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcdf_pkg::div_rec_t rec_i,
  output dcdf_pkg::div_rec_t rec_o
);

  dcdf_pkg::div_rec_t rec_d, rec_q;

  // The partial remainder stays below the divisor, so one extra bit holds
  // the shifted value before the trial subtract.
  always_comb begin
    logic [dcdf_pkg::SPAN_W:0] trial;
    rec_d = rec_i;
    for (int unsigned k = 0; k < dcdf_pkg::DIV_BITS_PER_STAGE; k++) begin
      trial    = {rec_d.rem, rec_d.lq[dcdf_pkg::Y_PT_W-1]};
      rec_d.lq = {rec_d.lq[dcdf_pkg::Y_PT_W-2:0], 1'b0};
      if (trial >= {1'b0, rec_d.den}) begin
        rec_d.rem   = dcdf_pkg::SPAN_W'(trial - {1'b0, rec_d.den});
        rec_d.lq[0] = 1'b1;
      end else begin
        rec_d.rem = trial[dcdf_pkg::SPAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

@@ design/dcdf_curve_lane.sv @@
// ----------------------------------------------------------------------------
// dcdf_curve_lane: pipelined evaluation of one piecewise-linear curve
// Segment select, multiply, divide and final add, with the sensor fallbacks
// folded into the base value of the first stage.
// ----------------------------------------------------------------------------
module dcdf_curve_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [dcdf_pkg::XS_W-1:0]     x_i,
  input  logic                          ok_i,
  input  logic                          present_i,
  input  dcdf_pkg::xvec_t               xs_i,
  input  dcdf_pkg::yvec_t               ys_i,
  input  logic [dcdf_pkg::Y_PT_W-1:0]   no_der_i,
  input  logic [dcdf_pkg::Y_PT_W-1:0]   max_der_i,
  output logic                          vld_o,
  output logic [dcdf_pkg::Y_PT_W-1:0]   res_o
);

  localparam int unsigned DW = dcdf_pkg::XS_W + 1;

  dcdf_pkg::mul_rec_t s1_d, s1_q;
  dcdf_pkg::div_rec_t s2_d, s2_q;
  dcdf_pkg::div_rec_t div_rec [dcdf_pkg::DIV_STAGES+1];
  logic                        s7_vld_q;
  logic [dcdf_pkg::Y_PT_W-1:0] s7_res_d, s7_res_q;

  // Stage 1: scan the breakpoints from the first upward. The first point
  // above the input gives its own Y; a point whose successor lies above the
  // input starts an interpolation.
  always_comb begin
    logic                         found;
    logic                         interp;
    logic signed [DW-1:0]         dnum;
    logic signed [DW-1:0]         dden;
    logic [dcdf_pkg::Y_PT_W:0]    dy;
    found  = 1'b0;
    interp = 1'b0;
    dnum   = '0;
    dden   = DW'(1);
    dy     = '0;
    s1_d      = '0;
    s1_d.vld  = vld_i;
    s1_d.base = ys_i[dcdf_pkg::CURVE_POINTS-1];
    for (int unsigned i = 0; i + 1 < dcdf_pkg::CURVE_POINTS; i++) begin
      if (!found) begin
        if ($signed(x_i) < $signed(xs_i[i])) begin
          found     = 1'b1;
          s1_d.base = ys_i[i];
        end else if ($signed(x_i) < $signed(xs_i[i+1])) begin
          found     = 1'b1;
          interp    = 1'b1;
          s1_d.base = ys_i[i];
          dnum      = DW'($signed(x_i)) - DW'($signed(xs_i[i]));
          dden      = DW'($signed(xs_i[i+1])) - DW'($signed(xs_i[i]));
          dy        = {1'b0, ys_i[i+1]} - {1'b0, ys_i[i]};
        end
      end
    end
    if (!present_i) begin
      s1_d.base = no_der_i;
      interp    = 1'b0;
    end else if (!ok_i) begin
      s1_d.base = max_der_i;
      interp    = 1'b0;
    end
    if (interp) begin
      s1_d.neg  = dy[dcdf_pkg::Y_PT_W];
      s1_d.dmag = dy[dcdf_pkg::Y_PT_W] ? dcdf_pkg::Y_PT_W'(-dy)
                                       : dy[dcdf_pkg::Y_PT_W-1:0];
      s1_d.num  = dnum[dcdf_pkg::SPAN_W-1:0];
      s1_d.den  = dden[dcdf_pkg::SPAN_W-1:0];
    end else begin
      // A zero numerator over one makes the correction term vanish.
      s1_d.neg  = 1'b0;
      s1_d.dmag = '0;
      s1_d.num  = '0;
      s1_d.den  = dcdf_pkg::SPAN_W'(1);
    end
  end

  // Stage 2: the product. It stays below den * 2^16, so its upper byte is
  // already a valid starting remainder.
  always_comb begin
    logic [dcdf_pkg::PROD_W-1:0] prod;
    prod      = dcdf_pkg::PROD_W'(s1_q.dmag * s1_q.num);
    s2_d.vld  = s1_q.vld;
    s2_d.base = s1_q.base;
    s2_d.neg  = s1_q.neg;
    s2_d.den  = s1_q.den;
    s2_d.rem  = prod[dcdf_pkg::PROD_W-1:dcdf_pkg::Y_PT_W];
    s2_d.lq   = prod[dcdf_pkg::Y_PT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign div_rec[0] = s2_q;

  for (genvar g = 0; g < dcdf_pkg::DIV_STAGES; g++) begin : g_div
    dcdf_div_stage u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rec_i  (div_rec[g]),
      .rec_o  (div_rec[g+1])
    );
  end

  // Final stage: apply the sign of the slope; when interpolating, the sum
  // lands between the two neighboring Y values.
  always_comb begin
    dcdf_pkg::div_rec_t r;
    r        = div_rec[dcdf_pkg::DIV_STAGES];
    s7_res_d = r.neg ? r.base - r.lq : r.base + r.lq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= div_rec[dcdf_pkg::DIV_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_res_q <= s7_res_d;
  end

  assign vld_o = s7_vld_q;
  assign res_o = s7_res_q;

endmodule

@@ design/dual_curve_derating_factor_core.sv @@
// ----------------------------------------------------------------------------
// dual_curve_derating_factor_core: voltage and temperature derating factor
// Evaluates two configurable piecewise-linear derating curves and reports
// the smaller of the two values.
// ----------------------------------------------------------------------------
// Usage:
// A request is the pair of measurements with their validity flags. It is
// taken at a rising edge with start_i high and busy_o low. busy_o is high
// only during reset and until the first rising edge after it; after that
// a new request may be issued in every cycle.
// Each request yields exactly one result, shown on the result ports for a
// single cycle with done_o high. The request passes in order through the
// pipeline registers: segment select, multiply, four divider stages of four
// quotient bits each, the final add and the output register.
// Throughput is one request per cycle; results leave in request order.
// The receiver cannot hold results off, so nothing here ever stalls.
// Configuration registers are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i and take effect at once; write them only while no request is
// in flight. Reset returns the registers to their defaults (flat zero
// curves, no-derating 1000, max-derating 0, both sensors present) and
// empties the pipeline.
// ----------------------------------------------------------------------------
module dual_curve_derating_factor_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [7:0]                      supply_voltage_i,
  input  logic                            voltage_valid_i,
  input  logic signed [7:0]               temperature_i,
  input  logic                            temperature_valid_i,
  input  logic                            cfg_we_i,
  input  logic [dcdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcdf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [15:0]                     derating_factor_o,
  output logic [15:0]                     voltage_derating_o,
  output logic [15:0]                     temperature_derating_o,
  output logic                            thermal_limit_active_o
);

  dcdf_pkg::cfg_t  cfg;
  dcdf_pkg::xvec_t volt_xs, temp_xs;
  dcdf_pkg::yvec_t volt_ys, temp_ys;

  logic        busy_q;
  logic        accept;
  logic        v_vld, t_vld;
  logic [15:0] v_res, t_res;

  logic        done_q;
  logic [15:0] factor_d, factor_q;
  logic [15:0] vd_q, td_q;
  logic        flag_d, flag_q;

  // busy_o holds off requests until the first rising edge after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i & ~busy_q;

  dcdf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Unpack the breakpoints. Voltage points are unsigned and temperature
  // points signed; both go into one signed domain one bit wider, so a
  // single lane design serves both curves.
  always_comb begin
    for (int unsigned i = 0; i < dcdf_pkg::CURVE_POINTS; i++) begin
      volt_xs[i] = dcdf_pkg::x_point(cfg.volt_x, i, 1'b0);
      temp_xs[i] = dcdf_pkg::x_point(cfg.temp_x, i, 1'b1);
      volt_ys[i] = dcdf_pkg::y_point(cfg.volt_y, i);
      temp_ys[i] = dcdf_pkg::y_point(cfg.temp_y, i);
    end
  end

  dcdf_curve_lane u_volt_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (accept),
    .x_i       ({1'b0, supply_voltage_i}),
    .ok_i      (voltage_valid_i),
    .present_i (cfg.present[dcdf_pkg::SENSOR_VOLT_BIT]),
    .xs_i      (volt_xs),
    .ys_i      (volt_ys),
    .no_der_i  (cfg.no_der),
    .max_der_i (cfg.max_der),
    .vld_o     (v_vld),
    .res_o     (v_res)
  );

  dcdf_curve_lane u_temp_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (accept),
    .x_i       ({temperature_i[7], temperature_i}),
    .ok_i      (temperature_valid_i),
    .present_i (cfg.present[dcdf_pkg::SENSOR_TEMP_BIT]),
    .xs_i      (temp_xs),
    .ys_i      (temp_ys),
    .no_der_i  (cfg.no_der),
    .max_der_i (cfg.max_der),
    .vld_o     (t_vld),
    .res_o     (t_res)
  );

  // Output stage: minimum of the two partial values and the thermal flag.
  // The lanes run in lockstep, so their valid bits always agree.
  assign factor_d = (v_res < t_res) ? v_res : t_res;
  assign flag_d   = (t_res < cfg.no_der);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_vld & t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    vd_q     <= v_res;
    td_q     <= t_res;
    flag_q   <= flag_d;
  end

  assign done_o                 = done_q;
  assign derating_factor_o      = factor_q;
  assign voltage_derating_o     = vd_q;
  assign temperature_derating_o = td_q;
  assign thermal_limit_active_o = flag_q;

endmodule

@@ design/dcdf_checker.sv @@
// ----------------------------------------------------------------------------
// dcdf_checker: port-level checks for the derating factor core
// Watches request/result timing and the consistency of the result fields.
// ----------------------------------------------------------------------------
module dcdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] derating_factor_o,
  input logic [15:0] voltage_derating_o,
  input logic [15:0] temperature_derating_o
);

  localparam int unsigned LAT = dcdf_pkg::PIPE_LATENCY;

  // Every accepted request produces its result after the fixed latency.
  a_req_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o
  ) else $error("request did not produce a result on time");

  // No result appears without a request that latency ago.
  a_result_has_req: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT)
  ) else $error("result without a matching request");

  // The reported factor is the smaller of the two partial values.
  a_factor_is_min: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (derating_factor_o == ((voltage_derating_o < temperature_derating_o)
                                      ? voltage_derating_o : temperature_derating_o))
  ) else $error("derating factor is not the minimum of the partial values");

endmodule

bind dual_curve_derating_factor_core dcdf_checker u_dcdf_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .start_i                (start_i),
  .busy_o                 (busy_o),
  .done_o                 (done_o),
  .derating_factor_o      (derating_factor_o),
  .voltage_derating_o     (voltage_derating_o),
  .temperature_derating_o (temperature_derating_o)
);
